/* hdl/rzp_pkg.sv */
// ----------------------------------------------------------------------------
// rzp_pkg
// Shared types and constants of the readahead zone planner.
// ----------------------------------------------------------------------------
package rzp_pkg;

    localparam int PSIZE_W       = 25;
    localparam int OFFSET_W      = 40;
    localparam int PIECE_W       = 20;
    localparam int COUNT_W       = 8;
    localparam int BOUND_W       = 21;
    localparam int TIME_W        = 32;
    localparam int DIVIDEND_W    = OFFSET_W + 1;
    localparam int CALC_W        = 23;
    localparam int NUM_BOUNDS    = 10;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 40;
    localparam int DIV_STEPS     = DIVIDEND_W;
    localparam int DIV_CNT_W     = 6;
    localparam int ZONE_IDX_W    = 2;
    localparam int IN_DATA_W     = 72;
    localparam int OUT_DATA_W    = 216;

    // event kinds
    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_STALL   = 2'd1;
    localparam logic [1:0] ACT_RECOVER = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PSIZE       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FILE_OFFSET = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_PIECE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LAST_PIECE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CRITICAL    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_URGENT      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PREFETCH    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPECULATIVE = 3'd7;

    // reset values of the registers
    localparam logic [PSIZE_W-1:0]      RST_PSIZE       = 25'd262144;
    localparam logic [COUNT_W-1:0]      RST_CRITICAL    = 8'd2;
    localparam logic [COUNT_W-1:0]      RST_URGENT      = 8'd4;
    localparam logic [COUNT_W-1:0]      RST_PREFETCH    = 8'd8;
    localparam logic [COUNT_W-1:0]      RST_SPECULATIVE = 8'd8;

    localparam logic [BOUND_W-1:0] BOUND_EMPTY = '1;

    typedef enum logic [1:0] {
        EMIT_REBUILT,
        EMIT_HELD,
        EMIT_EMPTY
    } emit_kind_t;

    typedef struct packed {
        logic                  capture;
        logic                  set_stall;
        logic                  load_seen_cur;
        logic                  load_first_cur;
        logic                  div_init;
        logic                  div_step;
        logic                  clamp;
        logic                  mark_rebuild;
        logic                  zone_step;
        logic [ZONE_IDX_W-1:0] zone_idx;
        logic                  tail_step;
        logic                  load_out;
        emit_kind_t            emit_kind;
    } rzp_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       seen_valid;
        logic       size_zero;
        logic       hold_hit;
        logic       out_free;
    } rzp_status_t;

endpackage

/* hdl/readahead_zone_planner.sv */
// ----------------------------------------------------------------------------
// readahead_zone_planner
// Maps read, stall and recovery events to five piece zones around the playhead.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  s_*       in   tuser: action; tdata: read_offset, now_ms
//  m_*       out  tuser: stall flag, rebuilt; tdata: ten zone bounds
//  cfg_*     in   register index and write data, one write per cycle
//
//  A read runs through the one-bit-a-cycle 41-step divider; a held
//  read (same piece within the hold time) still divides but skips the zone
//  build; a read with zero piece size skips the divider, and a stall or
//  recovery event skips it too. One item is in flight at a time; the
//  next is taken while a finished result waits in the output register. A
//  stalled output holds the sequencer before it loads the next result. Reset
//  is synchronous and needs no clearing pass.
module readahead_zone_planner #(
    parameter int TAIL_LEN             = 2,
    parameter int URGENT_STALL_ADD     = 4,
    parameter int PREFETCH_STALL_ADD   = 4,
    parameter int HOLD_MS              = 1000
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rzp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rzp_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rzp_pkg::IN_DATA_W-1:0]       s_tdata,   // read_offset, now_ms
    input  logic [1:0]                          s_tuser,   // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // critical_start/end, urgent_start/end, prefetch_start/end,
    // spec_start/end, tail_start/end, zero pad
    output logic [rzp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [1:0]                          m_tuser    // stall flag, rebuilt
);
    import rzp_pkg::*;

    rzp_cmd_t    cmd;
    rzp_status_t status;

    rzp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rzp_dp #(
        .TAIL_LEN             (TAIL_LEN),
        .URGENT_STALL_ADD     (URGENT_STALL_ADD),
        .PREFETCH_STALL_ADD   (PREFETCH_STALL_ADD),
        .HOLD_MS              (HOLD_MS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

/* hdl/rzp_ctrl.sv */
// ----------------------------------------------------------------------------
// rzp_ctrl
// Sequencer: decode, divide, clamp, hold check, zone build and result load.
// ----------------------------------------------------------------------------
module rzp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rzp_pkg::rzp_status_t status,
    output rzp_pkg::rzp_cmd_t    cmd
);
    import rzp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_CLAMP,
        ST_CHECK,
        ST_ZONE,
        ST_TAIL,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ZONE_IDX_W-1:0]   zone_reg, zone_next;
    emit_kind_t              kind_reg, kind_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        zone_next  = zone_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.zone_idx  = zone_reg;
        cmd.emit_kind = kind_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                zone_next = '0;
                case (status.action)
                    ACT_READ: begin
                        if (status.size_zero) begin
                            cmd.load_first_cur = 1'b1;
                            state_next         = ST_CHECK;
                        end else begin
                            cmd.div_init = 1'b1;
                            cnt_next     = '0;
                            state_next   = ST_DIV;
                        end
                    end
                    ACT_STALL, ACT_RECOVER: begin
                        cmd.set_stall = 1'b1;
                        if (status.seen_valid) begin
                            cmd.load_seen_cur = 1'b1;
                            kind_next         = EMIT_REBUILT;
                            state_next        = ST_ZONE;
                        end else begin
                            kind_next  = EMIT_EMPTY;
                            state_next = ST_EMIT;
                        end
                    end
                    default: state_next = ST_IDLE;   // drop unused code
                endcase
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.hold_hit) begin
                    kind_next  = EMIT_HELD;
                    state_next = ST_EMIT;
                end else begin
                    cmd.mark_rebuild = 1'b1;
                    kind_next        = EMIT_REBUILT;
                    state_next       = ST_ZONE;
                end
            end
            ST_ZONE: begin
                cmd.zone_step = 1'b1;
                zone_next     = zone_reg + 1'b1;
                if (zone_reg == '1)
                    state_next = ST_TAIL;
            end
            ST_TAIL: begin
                cmd.tail_step = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            zone_reg  <= '0;
            kind_reg  <= EMIT_EMPTY;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            zone_reg  <= zone_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

/* hdl/rzp_dp.sv */
// ----------------------------------------------------------------------------
// rzp_dp
// Datapath: registers, bit-serial divider, zone arithmetic, snapshot, output.
// ----------------------------------------------------------------------------
module rzp_dp #(
    parameter int TAIL_LEN             = 2,
    parameter int URGENT_STALL_ADD     = 4,
    parameter int PREFETCH_STALL_ADD   = 4,
    parameter int HOLD_MS              = 1000
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rzp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rzp_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic [rzp_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rzp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [1:0]                          m_tuser,
    input  rzp_pkg::rzp_cmd_t                   cmd,
    output rzp_pkg::rzp_status_t                status
);
    import rzp_pkg::*;

    typedef logic signed [CALC_W-1:0] calc_t;

    // configuration
    logic [PSIZE_W-1:0]      psize_reg;
    logic [OFFSET_W-1:0]     file_offset_reg;
    logic [PIECE_W-1:0]      first_piece_reg, last_piece_reg;
    logic [COUNT_W-1:0]      critical_reg, urgent_reg, prefetch_reg, spec_reg;

    // item state
    logic [1:0]              action_reg;
    logic [TIME_W-1:0]       now_reg;
    logic [DIVIDEND_W-1:0]   quot_reg;
    logic [PSIZE_W:0]        rem_reg;
    logic [PIECE_W-1:0]      cur_reg;
    calc_t                   prev_end_reg;

    // persistent state
    logic signed [BOUND_W-1:0] seen_reg;
    logic [TIME_W-1:0]         rb_time_reg;
    logic                      rb_valid_reg;
    logic                      stalled_reg;
    logic                      snap_stall_reg;
    logic [BOUND_W-1:0]        bounds_reg [NUM_BOUNDS];

    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;
    logic [1:0]                out_user_reg;

    // divider step
    logic [PSIZE_W:0]   shifted;
    logic [PSIZE_W+1:0] trial;
    assign shifted = {rem_reg[PSIZE_W-1:0], quot_reg[DIVIDEND_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, psize_reg};

    // clamp of the quotient
    logic [DIVIDEND_W-1:0] q_lo, q_clamped;
    always_comb begin
        q_lo      = (quot_reg < DIVIDEND_W'(first_piece_reg)) ?
                    DIVIDEND_W'(first_piece_reg) : quot_reg;
        q_clamped = (q_lo > DIVIDEND_W'(last_piece_reg)) ?
                    DIVIDEND_W'(last_piece_reg) : q_lo;
    end

    // hold check
    logic [TIME_W-1:0] elapsed;
    assign elapsed = now_reg - rb_time_reg;

    // zone arithmetic
    calc_t lo_s, hi_s, cur_s, start_s, end_raw, end_s;
    calc_t tail_s, tail_e, tail_s2, tail_e2;
    logic [COUNT_W:0] urg_len, pre_len, zone_len;
    logic [2*BOUND_W-1:0] zone_clip, tail_clip;

    function automatic logic [2*BOUND_W-1:0] clip_zone(calc_t s, calc_t e,
                                                       calc_t lo, calc_t hi);
        calc_t s2, e2;
        s2 = (s < lo) ? lo : s;
        e2 = (e > hi) ? hi : e;
        if (s < 0 || e < s || hi < lo || e2 < s2)
            return {BOUND_EMPTY, BOUND_EMPTY};
        return {e2[BOUND_W-1:0], s2[BOUND_W-1:0]};
    endfunction

    always_comb begin
        lo_s    = calc_t'({3'b000, first_piece_reg});
        hi_s    = calc_t'({3'b000, last_piece_reg});
        cur_s   = calc_t'({3'b000, cur_reg});
        urg_len = {1'b0, urgent_reg} +
                  (stalled_reg ? (COUNT_W+1)'(URGENT_STALL_ADD) : '0);
        pre_len = {1'b0, prefetch_reg} +
                  (stalled_reg ? (COUNT_W+1)'(PREFETCH_STALL_ADD) : '0);
        if (urg_len < (COUNT_W+1)'(2)) urg_len = (COUNT_W+1)'(2);
        if (pre_len < (COUNT_W+1)'(2)) pre_len = (COUNT_W+1)'(2);
        case (cmd.zone_idx)
            2'd0:    zone_len = {1'b0, critical_reg};
            2'd1:    zone_len = urg_len;
            2'd2:    zone_len = pre_len;
            default: zone_len = stalled_reg ? '0 : {1'b0, spec_reg};
        endcase
        start_s   = (cmd.zone_idx == '0) ? cur_s : prev_end_reg + calc_t'(1);
        end_raw   = start_s + calc_t'({{(CALC_W-COUNT_W-1){1'b0}}, zone_len}) - calc_t'(1);
        end_s     = (end_raw > hi_s) ? hi_s : end_raw;
        zone_clip = clip_zone(start_s, end_s, lo_s, hi_s);

        tail_s  = cur_s - calc_t'(TAIL_LEN);
        tail_e  = cur_s - calc_t'(1);
        tail_s2 = (tail_s < lo_s) ? lo_s : tail_s;
        tail_e2 = (tail_e < lo_s) ? lo_s : tail_e;
        if (tail_e2 < tail_s2) begin
            tail_s2 = -calc_t'(1);
            tail_e2 = -calc_t'(1);
        end
        tail_clip = clip_zone(tail_s2, tail_e2, lo_s, hi_s);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psize_reg       <= RST_PSIZE;
            file_offset_reg <= '0;
            first_piece_reg <= '0;
            last_piece_reg  <= '0;
            critical_reg    <= RST_CRITICAL;
            urgent_reg      <= RST_URGENT;
            prefetch_reg    <= RST_PREFETCH;
            spec_reg        <= RST_SPECULATIVE;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PSIZE:       psize_reg       <= cfg_wr_data[PSIZE_W-1:0];
                REG_FILE_OFFSET: file_offset_reg <= cfg_wr_data[OFFSET_W-1:0];
                REG_FIRST_PIECE: first_piece_reg <= cfg_wr_data[PIECE_W-1:0];
                REG_LAST_PIECE:  last_piece_reg  <= cfg_wr_data[PIECE_W-1:0];
                REG_CRITICAL:    critical_reg    <= cfg_wr_data[COUNT_W-1:0];
                REG_URGENT:      urgent_reg      <= cfg_wr_data[COUNT_W-1:0];
                REG_PREFETCH:    prefetch_reg    <= cfg_wr_data[COUNT_W-1:0];
                REG_SPECULATIVE: spec_reg        <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_tuser;
            now_reg    <= s_tdata[OFFSET_W +: TIME_W];
            quot_reg   <= {1'b0, file_offset_reg} + {1'b0, s_tdata[OFFSET_W-1:0]};
        end
        if (cmd.div_init)
            rem_reg <= '0;
        if (cmd.div_step) begin
            if (!trial[PSIZE_W+1]) begin
                rem_reg  <= trial[PSIZE_W:0];
                quot_reg <= {quot_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_reg  <= shifted;
                quot_reg <= {quot_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
        if (cmd.clamp)
            cur_reg <= q_clamped[PIECE_W-1:0];
        if (cmd.load_first_cur)
            cur_reg <= first_piece_reg;
        if (cmd.load_seen_cur)
            cur_reg <= seen_reg[PIECE_W-1:0];
        if (cmd.zone_step)
            prev_end_reg <= end_s;
        if (cmd.load_out) begin
            for (int i = 0; i < NUM_BOUNDS; i++)
                out_data_reg[i*BOUND_W +: BOUND_W] <=
                    (cmd.emit_kind == EMIT_EMPTY) ? BOUND_EMPTY : bounds_reg[i];
            out_data_reg[OUT_DATA_W-1:NUM_BOUNDS*BOUND_W] <= '0;
            out_user_reg[0] <= (cmd.emit_kind == EMIT_EMPTY) ? 1'b0 : snap_stall_reg;
            out_user_reg[1] <= (cmd.emit_kind == EMIT_REBUILT);
        end
    end

    // persistent state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= '1;
            rb_time_reg    <= '0;
            rb_valid_reg   <= 1'b0;
            stalled_reg    <= 1'b0;
            snap_stall_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_BOUNDS; i++)
                bounds_reg[i] <= BOUND_EMPTY;
        end else begin
            if (cmd.set_stall)
                stalled_reg <= (action_reg == ACT_STALL);
            if (cmd.mark_rebuild) begin
                rb_time_reg  <= now_reg;
                rb_valid_reg <= 1'b1;
                seen_reg     <= {1'b0, cur_reg};
            end
            if (cmd.zone_step) begin
                bounds_reg[{1'b0, cmd.zone_idx, 1'b0}] <= zone_clip[BOUND_W-1:0];
                bounds_reg[{1'b0, cmd.zone_idx, 1'b1}] <= zone_clip[2*BOUND_W-1:BOUND_W];
            end
            if (cmd.tail_step) begin
                bounds_reg[NUM_BOUNDS-2] <= tail_clip[BOUND_W-1:0];
                bounds_reg[NUM_BOUNDS-1] <= tail_clip[2*BOUND_W-1:BOUND_W];
                snap_stall_reg           <= stalled_reg;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.action     = action_reg;
    assign status.seen_valid = !seen_reg[BOUND_W-1];
    assign status.size_zero  = (psize_reg == '0);
    assign status.hold_hit   = (seen_reg == {1'b0, cur_reg}) && rb_valid_reg &&
                               (elapsed < TIME_W'(HOLD_MS));
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
